// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the label filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/wmlf_pkg.sv -----
// ----------------------------------------------------------------------------
// wmlf_pkg
// Types and constants shared by the weighted majority label filter.
// ----------------------------------------------------------------------------
package wmlf_pkg;

    localparam int MAX_HALF_WINDOW = 15;
    localparam int WIN_DEPTH       = 2 * MAX_HALF_WINDOW + 1;
    localparam int WIN_IDX_W       = $clog2(WIN_DEPTH);
    localparam int M_W             = $clog2(MAX_HALF_WINDOW + 1);
    localparam int VOTE_W          = $clog2(WIN_DEPTH + 1);
    localparam int FRAMES_W        = 6;
    localparam int FRAMES_MAX      = (1 << FRAMES_W) - 1;
    localparam int FLUSH_DEPTH     = MAX_HALF_WINDOW;
    localparam int FLUSH_CNT_W     = $clog2(FLUSH_DEPTH + 1);
    localparam int FLUSH_IDX_W     = (FLUSH_DEPTH > 1) ? $clog2(FLUSH_DEPTH) : 1;

    localparam int HW_W     = 4;
    localparam int BIAS_W   = 12;
    localparam int FRAC_W   = 8;
    localparam int PROD_W   = BIAS_W + VOTE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_BIAS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELABEL_QUIET = 2'd2;

    localparam logic [BIAS_W-1:0] ZERO_BIAS_RESET = 12'd256;

    typedef logic [1:0] t_lbl;
    localparam t_lbl LBL_ZERO   = 2'b00;
    localparam t_lbl LBL_ONE    = 2'b01;
    localparam t_lbl LBL_SILENT = 2'b11;

    typedef struct packed {
        logic label;
        logic loud;
        logic last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [1:0] out_label;
        logic              last_out;
    } t_out_item;

    typedef struct packed {
        logic                             has_main;
        t_lbl                             main_label;
        logic                             last;
        logic [FLUSH_CNT_W-1:0]           flush_cnt;
        logic [FLUSH_DEPTH-1:0][1:0]      win;
    } t_cmd;

endpackage

// ----- hw/rtl/wmlf_front.sv -----
// ----------------------------------------------------------------------------
// wmlf_front
// Config registers, label window, vote counts; emits one output command
// per item that yields results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wmlf_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wmlf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wmlf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_push,
    input  wmlf_pkg::t_in_item              i_item,
    input  logic                            i_q_full,
    output logic                            o_cmd_valid,
    output wmlf_pkg::t_cmd                  o_cmd
);
    import wmlf_pkg::*;

    logic [HW_W-1:0]     r_half_window;
    logic [BIAS_W-1:0]   r_zero_bias;
    logic                r_relabel;
    t_lbl                r_win [WIN_DEPTH];
    logic [FRAMES_W-1:0] r_frames;
    logic [VOTE_W-1:0]   r_zero;
    logic [VOTE_W-1:0]   r_one;
    logic [M_W-1:0]      r_active_m;

    t_lbl                n_win [WIN_DEPTH];
    logic [VOTE_W-1:0]   n_zero;
    logic [VOTE_W-1:0]   n_one;
    logic [VOTE_W-1:0]   dec_zero;
    logic [VOTE_W-1:0]   dec_one;
    logic [FRAMES_W-1:0] n_frames;
    logic [M_W-1:0]      m;
    logic                accept;
    t_lbl                lbl;
    t_lbl                leaving;
    logic                has_main;
    logic                vote_ok;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   ones_scaled;
    t_lbl                main_label;

    assign accept = i_push && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_window <= '0;
            r_zero_bias   <= ZERO_BIAS_RESET;
            r_relabel     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HALF_WINDOW:   r_half_window <= i_cfg_data[HW_W-1:0];
                CFG_ZERO_BIAS:     r_zero_bias   <= i_cfg_data[BIAS_W-1:0];
                CFG_RELABEL_QUIET: r_relabel     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        lbl = (r_relabel && !i_item.loud) ? LBL_SILENT : {1'b0, i_item.label};

        if (r_frames == '0) begin
            if (32'(r_half_window) > MAX_HALF_WINDOW) begin
                m = M_W'(MAX_HALF_WINDOW);
            end else begin
                m = M_W'(r_half_window);
            end
        end else begin
            m = r_active_m;
        end

        leaving = r_win[WIN_IDX_W'({m, 1'b0})];
        dec_zero = r_zero;
        dec_one  = r_one;
        if (leaving == LBL_ZERO && r_zero != '0) begin
            dec_zero = r_zero - 1'b1;
        end else if (leaving == LBL_ONE && r_one != '0) begin
            dec_one = r_one - 1'b1;
        end
        n_zero = (lbl == LBL_ZERO) ? VOTE_W'(dec_zero + 1'b1) : dec_zero;
        n_one  = (lbl == LBL_ONE)  ? VOTE_W'(dec_one + 1'b1)  : dec_one;

        n_win[0] = lbl;
        for (int i = 1; i < WIN_DEPTH; i++) begin
            n_win[i] = r_win[i-1];
        end

        has_main    = r_frames >= FRAMES_W'(m);
        vote_ok     = (m != '0) && (r_frames >= FRAMES_W'({m, 1'b0}));
        prod        = PROD_W'(r_zero_bias) * PROD_W'(n_zero);
        ones_scaled = PROD_W'({n_one, {FRAC_W{1'b0}}});
        if (vote_ok) begin
            main_label = (prod > ones_scaled) ? LBL_ZERO : LBL_ONE;
        end else begin
            main_label = n_win[WIN_IDX_W'(m)];
        end

        n_frames = (r_frames != FRAMES_W'(FRAMES_MAX)) ? FRAMES_W'(r_frames + 1'b1)
                                                      : r_frames;

        o_cmd.has_main   = has_main;
        o_cmd.main_label = main_label;
        o_cmd.last       = i_item.last_in;
        if (!i_item.last_in) begin
            o_cmd.flush_cnt = '0;
        end else if (has_main) begin
            o_cmd.flush_cnt = FLUSH_CNT_W'(m);
        end else begin
            o_cmd.flush_cnt = FLUSH_CNT_W'(r_frames + 1'b1);
        end
        for (int i = 0; i < FLUSH_DEPTH; i++) begin
            o_cmd.win[i] = n_win[i];
        end
        o_cmd_valid = accept && (has_main || i_item.last_in);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
                r_win[i] <= LBL_SILENT;
            end
            r_frames   <= '0;
            r_zero     <= '0;
            r_one      <= '0;
            r_active_m <= '0;
        end else if (accept) begin
            r_active_m <= m;
            if (i_item.last_in) begin
                for (int i = 0; i < WIN_DEPTH; i++) begin
                    r_win[i] <= LBL_SILENT;
                end
                r_frames <= '0;
                r_zero   <= '0;
                r_one    <= '0;
            end else begin
                r_win    <= n_win;
                r_frames <= n_frames;
                r_zero   <= n_zero;
                r_one    <= n_one;
            end
        end
    end

    `ASSERT_IMPLY(a_cmd_nonempty, i_clk, i_rst_n, o_cmd_valid,
                  o_cmd.has_main || o_cmd.flush_cnt != '0)
    `ASSERT_ALWAYS(a_votes_fit, i_clk, i_rst_n,
                   32'(r_zero) + 32'(r_one) <= WIN_DEPTH)

endmodule

// ----- hw/rtl/wmlf_queue.sv -----
// ----------------------------------------------------------------------------
// wmlf_queue
// Short command queue between the window front and the output sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wmlf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  wmlf_pkg::t_cmd i_wr_data,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_rd,
    output wmlf_pkg::t_cmd o_rd_data
);
    import wmlf_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    logic              do_wr;
    logic              do_rd;

    assign o_full    = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_valid   = r_cnt != '0;
    assign o_rd_data = r_mem[r_rp];
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (32'(r_wp) == QUEUE_DEPTH - 1) ? '0 : QPTR_W'(r_wp + 1'b1);
            end
            if (do_rd) begin
                r_rp <= (32'(r_rp) == QUEUE_DEPTH - 1) ? '0 : QPTR_W'(r_rp + 1'b1);
            end
            if (do_wr && !do_rd) begin
                r_cnt <= QCNT_W'(r_cnt + 1'b1);
            end else if (do_rd && !do_wr) begin
                r_cnt <= QCNT_W'(r_cnt - 1'b1);
            end
        end
    end

    `ASSERT_IMPLY(a_no_write_when_full, i_clk, i_rst_n, o_full, !i_wr)

endmodule

// ----- hw/rtl/wmlf_back.sv -----
// ----------------------------------------------------------------------------
// wmlf_back
// Output sequencer: expands each command into result beats, main label
// first, then flushed window entries oldest first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wmlf_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  wmlf_pkg::t_cmd        i_q_data,
    output logic                  o_q_rd,
    output logic                  empty,
    input  logic                  pop,
    output wmlf_pkg::t_out_item   o_item
);
    import wmlf_pkg::*;

    t_cmd                   r_cmd;
    logic                   r_busy;
    logic                   r_main_pend;
    logic [FLUSH_CNT_W-1:0] r_rem;
    logic                   r_out_valid;
    t_out_item              r_out;

    t_cmd                   n_cmd;
    logic                   n_busy;
    logic                   n_main_pend;
    logic [FLUSH_CNT_W-1:0] n_rem;
    logic                   n_out_valid;
    t_out_item              n_out;

    logic                   step;
    logic                   final_beat;
    t_lbl                   em_label;

    always_comb begin
        step       = r_busy && (!r_out_valid || pop);
        final_beat = r_main_pend ? (r_rem == '0) : (r_rem == FLUSH_CNT_W'(1));
        em_label   = r_main_pend ? r_cmd.main_label
                                 : r_cmd.win[FLUSH_IDX_W'(r_rem - 1'b1)];
        o_q_rd     = i_q_valid && (!r_busy || (step && final_beat));

        n_cmd       = r_cmd;
        n_busy      = r_busy;
        n_main_pend = r_main_pend;
        n_rem       = r_rem;
        n_out       = r_out;
        n_out_valid = r_out_valid && !pop;

        if (step) begin
            n_out_valid     = 1'b1;
            n_out.out_label = em_label;
            n_out.last_out  = r_cmd.last && final_beat;
            if (r_main_pend) begin
                n_main_pend = 1'b0;
            end else begin
                n_rem = FLUSH_CNT_W'(r_rem - 1'b1);
            end
            if (final_beat) begin
                n_busy = 1'b0;
            end
        end
        if (o_q_rd) begin
            n_cmd       = i_q_data;
            n_busy      = 1'b1;
            n_main_pend = i_q_data.has_main;
            n_rem       = i_q_data.flush_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_main_pend <= 1'b0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_main_pend <= n_main_pend;
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
        end
    end

    assign empty  = !r_out_valid;
    assign o_item = r_out;

    `ASSERT_IMPLY(a_busy_has_work, i_clk, i_rst_n, r_busy, r_main_pend || r_rem != '0)
    `ASSERT_IMPLY(a_out_held, i_clk, i_rst_n, r_out_valid && !pop && !step,
                  n_out == r_out)

endmodule

// ----- hw/rtl/weighted_majority_label_filter.sv -----
// ----------------------------------------------------------------------------
// weighted_majority_label_filter
// A result beat is held in the command queue, then registered in the output
// sequencer; window results trail the input stream by M items.
// Throughput: 1 item per cycle while not full; a stream's last item releases
// up to M+1 beats, drained 1 per cycle as popped, behind a 2-entry queue.
// Reset: synchronous active low; window goes silent, counts clear, config
// returns to M=0, bias 1.0, relabel off.
// ----------------------------------------------------------------------------
module weighted_majority_label_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wmlf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wmlf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  wmlf_pkg::t_in_item              i_in_item,
    output logic                            empty,
    input  logic                            pop,
    output wmlf_pkg::t_out_item             o_out_item
);
    import wmlf_pkg::*;

    logic q_full;
    logic q_valid;
    logic q_rd;
    logic cmd_valid;
    t_cmd cmd;
    t_cmd q_data;

    assign full = q_full;

    wmlf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_item      (i_in_item),
        .i_q_full    (q_full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    wmlf_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (cmd_valid),
        .i_wr_data (cmd),
        .o_full    (q_full),
        .o_valid   (q_valid),
        .i_rd      (q_rd),
        .o_rd_data (q_data)
    );

    wmlf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_rd    (q_rd),
        .empty     (empty),
        .pop       (pop),
        .o_item    (o_out_item)
    );

endmodule
